// ----- rtl/cartridge_bank_mapper_core_defines.svh -----
// assertion macros for the cartridge bank mapper
// included by the rtl files that carry checks; no other dependencies
`ifndef CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CBM_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define CBM_ASSERT_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);
`else
`define CBM_ASSERT(lbl, ck, rs, prop, msg)
`define CBM_ASSERT_NEVER(lbl, ck, rs, cond, msg)
`endif
`endif

// ----- rtl/cbm_pkg.sv -----
// shared types, codes and helpers for the cartridge bank mapper
// used by every module of the block; no dependencies
package cbm_pkg;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_ROM_BANK_COUNT = 1'b0,
    CFG_RAM_BANK_COUNT = 1'b1
  } cfg_reg_t;

  // bus address regions by address bits 15:13
  localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
  localparam logic [2:0] RGN_BANK_LOW   = 3'd1;
  localparam logic [2:0] RGN_BANK_HIGH  = 3'd2;
  localparam logic [2:0] RGN_MODE       = 3'd3;
  localparam logic [2:0] RGN_RAM_WIN    = 3'd5;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] FILL_MISS      = 8'hFF;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ADDR_W     = 21;

  typedef struct packed {
    logic [7:0]  write_byte;
    logic [15:0] bus_addr;
    cmd_t        cmd;
  } item_t;

  typedef struct packed {
    logic [7:0]        fill_byte;
    logic [ADDR_W-1:0] cart_addr;
    logic              to_ram;
    logic              mapped;
  } result_t;

  typedef struct packed {
    logic [6:0] rom;
    logic [1:0] ram;
  } bank_mask_t;

  // highest power of two not above count, minus one; zero for a zero count
  function automatic logic [7:0] count_mask(input logic [7:0] count);
    logic [7:0] s;
    s = count;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    return s >> 1;
  endfunction

endpackage

// ----- rtl/cbm_cfg.sv -----
// configuration registers: bank counts held as their address masks
// depends on cbm_pkg
module cbm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cbm_pkg::bank_mask_t              mask
);

  logic [7:0] rom_full;
  logic [7:0] ram_full;

  always_comb begin
    rom_full = cbm_pkg::count_mask(cfg_data);
    ram_full = cbm_pkg::count_mask({5'd0, cfg_data[2:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask.rom <= 7'd1;
      mask.ram <= 2'd0;
    end else if (cfg_we) begin
      unique case (cbm_pkg::cfg_reg_t'(cfg_index))
        cbm_pkg::CFG_ROM_BANK_COUNT: mask.rom <= rom_full[6:0];
        cbm_pkg::CFG_RAM_BANK_COUNT: mask.ram <= ram_full[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/cbm_bank.sv -----
// bank state registers and the access decode that maps one request
// depends on cbm_pkg
module cbm_bank (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  cbm_pkg::item_t      item,
  input  cbm_pkg::bank_mask_t mask,
  output cbm_pkg::result_t    res
);

  logic       ram_enable;
  logic       bank_mode;
  logic [4:0] bank_low;
  logic [1:0] bank_high;
  logic       ram_enable_next;
  logic       bank_mode_next;
  logic [4:0] bank_low_next;
  logic [1:0] bank_high_next;

  logic [2:0] rgn;
  logic       is_wr;
  logic       ram_hit;
  logic [6:0] rom_bank;
  logic [1:0] ram_bank;

  always_comb begin
    rgn     = item.bus_addr[15:13];
    is_wr   = (item.cmd == cbm_pkg::CMD_WRITE);
    ram_hit = (rgn == cbm_pkg::RGN_RAM_WIN) && ram_enable;
    rom_bank = (bank_mode ? {2'd0, bank_low} : {bank_high, bank_low}) & mask.rom;
    ram_bank = bank_mode ? (bank_high & mask.ram) : 2'd0;

    ram_enable_next = ram_enable;
    bank_mode_next  = bank_mode;
    bank_low_next   = bank_low;
    bank_high_next  = bank_high;
    if (is_wr) begin
      unique case (rgn)
        cbm_pkg::RGN_RAM_ENABLE:
          ram_enable_next = (item.write_byte[3:0] == cbm_pkg::RAM_ENABLE_KEY);
        cbm_pkg::RGN_BANK_LOW:
          bank_low_next = (item.write_byte[4:0] == 5'd0) ? 5'd1 : item.write_byte[4:0];
        cbm_pkg::RGN_BANK_HIGH:
          bank_high_next = item.write_byte[1:0];
        cbm_pkg::RGN_MODE:
          bank_mode_next = (item.write_byte != 8'd0);
        default: ;
      endcase
    end

    res = '0;
    if (ram_hit) begin
      res.mapped    = 1'b1;
      res.to_ram    = 1'b1;
      res.cart_addr = {6'd0, ram_bank, item.bus_addr[12:0]};
    end else if (!is_wr) begin
      if (item.bus_addr[15:14] == 2'b00) begin
        res.mapped    = 1'b1;
        res.cart_addr = {5'd0, item.bus_addr};
      end else if (item.bus_addr[15:14] == 2'b01) begin
        res.mapped    = 1'b1;
        res.cart_addr = {rom_bank, item.bus_addr[13:0]};
      end else begin
        res.fill_byte = cbm_pkg::FILL_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= 1'b0;
      bank_mode  <= 1'b0;
      bank_low   <= 5'd1;
      bank_high  <= 2'd0;
    end else if (advance) begin
      ram_enable <= ram_enable_next;
      bank_mode  <= bank_mode_next;
      bank_low   <= bank_low_next;
      bank_high  <= bank_high_next;
    end
  end

endmodule

// ----- rtl/cartridge_bank_mapper_core.sv -----
// Cartridge bank mapper: each bus request is taken into an input register,
// decoded and mapped combinationally on its way to a result register; a result
// is presented from that result register, and one request is taken
// every cycle while the result side keeps up. Bank register writes take effect
// as their request moves into the result register, so the very next request
// already sees the new bank with no gap. Count registers are written through
// the configuration port and are stored as address masks.
// top level; depends on cbm_pkg, cbm_cfg, cbm_bank and the defines header
`include "cartridge_bank_mapper_core_defines.svh"
module cartridge_bank_mapper_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // bus_addr[15:0], write_byte[23:16]
  input  logic [0:0]                     s_tuser,   // cmd[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // cart_addr[20:0], fill_byte[28:21], zeros
  output logic [1:0]                     m_tuser,   // mapped[0], to_ram[1]
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                in_vld;
  cbm_pkg::item_t      in_item;
  logic                out_vld;
  cbm_pkg::result_t    out_res;
  cbm_pkg::result_t    res;
  cbm_pkg::bank_mask_t mask;
  logic                out_free;
  logic                advance;

  assign out_free = !out_vld || m_tready;
  assign advance  = in_vld && out_free;
  assign s_tready = !in_vld || out_free;

  cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mask      (mask)
  );

  cbm_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .mask    (mask),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= cbm_pkg::cmd_t'(s_tuser[0]);
      in_item.bus_addr   <= s_tdata[15:0];
      in_item.write_byte <= s_tdata[23:16];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {3'd0, out_res.fill_byte, out_res.cart_addr};
  assign m_tuser  = {out_res.to_ram, out_res.mapped};

  `CBM_ASSERT(a_unmapped_zero, clk, rst, (m_tvalid && !out_res.mapped) |-> (out_res.cart_addr == '0 && !out_res.to_ram), "unmapped result carries an address")
  `CBM_ASSERT_NEVER(a_fill_on_map, clk, rst, m_tvalid && out_res.mapped && (out_res.fill_byte != 8'd0), "fill set on a mapped result")
  `CBM_ASSERT(a_fill_code, clk, rst, m_tvalid |-> (out_res.fill_byte == 8'd0 || out_res.fill_byte == cbm_pkg::FILL_MISS), "bad fill value")
  `CBM_ASSERT(a_empty_ready, clk, rst, !in_vld |-> s_tready, "input register empty but not ready")

endmodule

// ----- tb/tb_cartridge_bank_mapper_core.sv -----
// self-checking bench for the cartridge bank mapper: bus requests go in as a
// stream, each decoded result is checked against a local model of the bank logic
// depends on cbm_pkg and cartridge_bank_mapper_core
module tb_cartridge_bank_mapper_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 40;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // model state
  logic [7:0] rom_count = 8'd2;
  logic [2:0] ram_count = 3'd0;
  logic       ram_on = 1'b0;
  logic       mode_on = 1'b0;
  logic [4:0] low_bank = 5'd1;
  logic [1:0] high_bank = 2'd0;

  cbm_pkg::result_t pending_maps[$];

  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned count_settings = 0;

  int unsigned burst_left = 0;
  int unsigned gap_max = 4;
  rx_style_t   rx_style = RX_OPEN;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  logic [15:0] rx_pat = 16'b1101_1000_1110_0101;

  cartridge_bank_mapper_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_cartridge_bank_mapper_core: done, errors");
      $finish;
    end
  end

  // largest power of two not above the count, less one
  function automatic logic [7:0] bank_mask(input logic [7:0] n);
    logic [8:0] p;
    p = 9'd1;
    if (n == 8'd0) return 8'd0;
    while ((p << 1) <= {1'b0, n}) p = p << 1;
    return 8'(p - 9'd1);
  endfunction

  function automatic cbm_pkg::result_t decode_access(input cbm_pkg::cmd_t c,
                                                     input logic [15:0] a,
                                                     input logic [7:0] d);
    cbm_pkg::result_t r;
    int unsigned rb, xb, offs;
    logic in_ram_win;
    r = '0;
    in_ram_win = (a >= 16'hA000) && (a < 16'hC000);
    rb = int'(low_bank) + (mode_on ? 0 : (int'(high_bank) << 5));
    rb = rb & int'(bank_mask(rom_count));
    xb = mode_on ? (int'(high_bank) & int'(bank_mask({5'd0, ram_count}))) : 0;
    offs = 0;
    if (c == cbm_pkg::CMD_WRITE) begin
      if (a < 16'h2000) begin
        ram_on = (d[3:0] == cbm_pkg::RAM_ENABLE_KEY);
      end else if (a < 16'h4000) begin
        low_bank = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
      end else if (a < 16'h6000) begin
        high_bank = d[1:0];
      end else if (a < 16'h8000) begin
        mode_on = (d != 8'd0);
      end else if (in_ram_win && ram_on) begin
        r.mapped = 1'b1;
        r.to_ram = 1'b1;
        offs = xb * 32'h2000 + (int'(a) - 32'hA000);
      end
    end else begin
      if (a < 16'h4000) begin
        r.mapped = 1'b1;
        offs = int'(a);
      end else if (a < 16'h8000) begin
        r.mapped = 1'b1;
        offs = rb * 32'h4000 + (int'(a) - 32'h4000);
      end else if (in_ram_win && ram_on) begin
        r.mapped = 1'b1;
        r.to_ram = 1'b1;
        offs = xb * 32'h2000 + (int'(a) - 32'hA000);
      end else begin
        r.fill_byte = cbm_pkg::FILL_MISS;
      end
    end
    r.cart_addr = offs[cbm_pkg::ADDR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got,
               want);
    err_count++;
  endtask

  // result side
  always @(posedge clk) begin
    rx_pat <= {rx_pat[0], rx_pat[15:1]};
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:   m_tready <= rx_pat[0];
      endcase
    end
  end

  always @(posedge clk) begin
    cbm_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result, m_tdata", m_tdata, 0);
      end else begin
        want = pending_maps.pop_front();
        if (m_tuser[0] !== want.mapped) report_mismatch("mapped", m_tuser[0], want.mapped);
        if (m_tuser[1] !== want.to_ram) report_mismatch("to_ram", m_tuser[1], want.to_ram);
        if (m_tdata[20:0] !== want.cart_addr)
          report_mismatch("cart_addr", m_tdata[20:0], want.cart_addr);
        if (m_tdata[28:21] !== want.fill_byte)
          report_mismatch("fill_byte", m_tdata[28:21], want.fill_byte);
      end
    end
  end

  task automatic send_request(input cbm_pkg::cmd_t c, input logic [15:0] a,
                              input logic [7:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {d, a};
    s_tuser <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_maps.push_back(decode_access(c, a, d));
    requests_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input cbm_pkg::cfg_reg_t idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cbm_pkg::CFG_ROM_BANK_COUNT) rom_count = v;
    else ram_count = v[2:0];
  endtask

  task automatic set_counts(input logic [7:0] rom_n, input logic [7:0] ram_n);
    drain();
    write_count(cbm_pkg::CFG_ROM_BANK_COUNT, rom_n);
    write_count(cbm_pkg::CFG_RAM_BANK_COUNT, ram_n);
    count_settings++;
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [15:0] a;
    logic [7:0] d;
    cbm_pkg::cmd_t c;
    pick = $urandom_range(0, 99);
    d = 8'($urandom);
    c = cbm_pkg::cmd_t'($urandom_range(0, 1));
    if (pick < 8) begin
      // enable ram, pick the high bank and the mode, then work in the ram window
      send_request(cbm_pkg::CMD_WRITE, 16'($urandom_range(0, 16'h1FFF)),
                   {4'($urandom), cbm_pkg::RAM_ENABLE_KEY});
      send_request(cbm_pkg::CMD_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)), 8'($urandom));
      send_request(cbm_pkg::CMD_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)),
                   ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom));
      repeat (3)
        send_request(cbm_pkg::cmd_t'($urandom_range(0, 1)),
                     16'hA000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
    end else if (pick < 35) begin
      a = 16'($urandom_range(0, 16'h7FFF));
      if (a[14:13] == cbm_pkg::RGN_RAM_ENABLE[1:0] && $urandom_range(0, 1) == 0)
        d[3:0] = cbm_pkg::RAM_ENABLE_KEY;
      if (a[14:13] == cbm_pkg::RGN_BANK_LOW[1:0] && $urandom_range(0, 3) == 0) d[4:0] = 5'd0;
      if (a[14:13] == cbm_pkg::RGN_MODE[1:0] && $urandom_range(0, 3) == 0) d = 8'd0;
      send_request(cbm_pkg::CMD_WRITE, a, d);
    end else if (pick < 65) begin
      send_request(cbm_pkg::CMD_READ, 16'($urandom_range(0, 16'h7FFF)), d);
    end else if (pick < 88) begin
      send_request(c, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), d);
    end else begin
      send_request(c, 16'($urandom), d);
    end
  endtask

  task automatic test_directed();
    gap_max = 0;
    rx_style = RX_OPEN;
    // reads under the reset banks and counts
    send_request(cbm_pkg::CMD_READ, 16'h0000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h3FFF, 8'hFF);
    send_request(cbm_pkg::CMD_READ, 16'h4000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h7FFF, 8'hFF);
    send_request(cbm_pkg::CMD_READ, 16'h8000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'hA000, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'hA000, 8'h55);
    send_request(cbm_pkg::CMD_READ, 16'hFFFF, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'hC000, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'h0000, 8'h0A);
    // zero ram count keeps the ram bank at zero
    send_request(cbm_pkg::CMD_READ, 16'hBFFF, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'hA123, 8'hAA);
    set_counts(8'd128, 8'd4);
    send_request(cbm_pkg::CMD_WRITE, 16'h2000, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h4000, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'h3FFF, 8'hE0);
    send_request(cbm_pkg::CMD_WRITE, 16'h2000, 8'hFF);
    send_request(cbm_pkg::CMD_WRITE, 16'h5FFF, 8'hFF);
    send_request(cbm_pkg::CMD_READ, 16'h7FFF, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'h6000, 8'h80);
    send_request(cbm_pkg::CMD_READ, 16'hBFFF, 8'h00);
    send_request(cbm_pkg::CMD_READ, 16'h4000, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'h7FFF, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'h1FFF, 8'h1B);
    send_request(cbm_pkg::CMD_READ, 16'hA000, 8'h00);
    send_request(cbm_pkg::CMD_WRITE, 16'h1000, 8'hFA);
    drain();
  endtask

  task automatic test_count_settings();
    logic [7:0] rom_list[6];
    logic [7:0] ram_list[6];
    rom_list = '{8'd2, 8'd128, 8'd3, 8'd64, 8'd127, 8'($urandom_range(2, 128))};
    ram_list = '{8'd0, 8'd4, 8'd1, 8'd2, 8'd3, 8'($urandom_range(0, 4))};
    for (int p = 0; p < 6; p++) begin
      set_counts(rom_list[p], ram_list[p]);
      gap_max = (p % 3 == 0) ? 0 : p * 2;
      rx_style = rx_style_t'(p % 3);
      repeat (80) random_request();
    end
    drain();
  endtask

  task automatic test_input_stall();
    set_counts(8'd32, 8'd4);
    gap_max = 0;
    rx_style = RX_OPEN;
    hold_asked++;
    repeat (80) random_request();
    drain();
  endtask

  task automatic test_random_mix();
    set_counts(8'($urandom_range(2, 128)), 8'($urandom_range(0, 4)));
    gap_max = 6;
    rx_style = RX_RANDOM;
    repeat (100) random_request();
    rx_style = RX_PATTERN;
    gap_max = 2;
    repeat (100) random_request();
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_count_settings();
    test_input_stall();
    test_random_mix();
    repeat (8) @(posedge clk);
    if (pending_maps.size() != 0) report_mismatch("results left outstanding", pending_maps.size(), 0);
    $display("tb_cartridge_bank_mapper_core: %0d requests over %0d count settings, %0d results",
             requests_sent, count_settings, results_seen);
    $display("tb_cartridge_bank_mapper_core: %0d mismatches in %0d cycles", err_count,
             cycle_count);
    if (err_count == 0) begin
      $display("tb_cartridge_bank_mapper_core: done, clean");
    end else begin
      $display("tb_cartridge_bank_mapper_core: done, errors");
    end
    $finish;
  end

endmodule
